>>> src/dftlp_pkg.sv
package dftlp_pkg;

  localparam int MaxModes    = 64;
  localparam int ModeW       = $clog2(MaxModes);
  localparam int TrigSteps   = 24;
  localparam int StepW       = $clog2(TrigSteps);
  localparam logic signed [33:0] TrigGain = 34'sd652032874;

  typedef enum logic [1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_MODE_COUNT   = 2'd1,
    CFG_PHASE_STEP   = 2'd2,
    CFG_COUNT_RECIP  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               command;
    logic [8:0]         sample_index;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_value;
    logic               index_error;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_MODE0, S_KSTART, S_PHMUL, S_PHMOD, S_REMMUL,
    S_TRIG_START, S_TRIG_WAIT, S_RD_ISSUE, S_RD_WAIT,
    S_MUL_HI, S_MUL_LO, S_MUL_ACC, S_WRITE, S_NEXTK,
    S_SC_HI, S_SC_LO, S_DONE
  } state_t;

  function automatic logic [31:0] arc_of(input logic [StepW-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0: a = 32'd536870912;   5'd1: a = 32'd316933406;
      5'd2: a = 32'd167458907;   5'd3: a = 32'd85004756;
      5'd4: a = 32'd42667331;    5'd5: a = 32'd21354465;
      5'd6: a = 32'd10679838;    5'd7: a = 32'd5340245;
      5'd8: a = 32'd2670163;     5'd9: a = 32'd1335087;
      5'd10: a = 32'd667544;     5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;     5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;       5'd19: a = 32'd1304;
      5'd20: a = 32'd652;        5'd21: a = 32'd326;
      5'd22: a = 32'd163;        5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> src/dftlp_ram.sv
module dftlp_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/dftlp_cordic.sv
module dftlp_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [33:0] cos_q,
  output logic signed [33:0] sin_q
);
  import dftlp_pkg::*;

  logic signed [33:0] x_r, y_r, z_r;
  logic [1:0]         quad_r;
  logic [StepW-1:0]   step_r;
  logic               run_r, done_r;
  logic signed [33:0] dx, dy, arc;

  assign dx  = y_r >>> step_r;
  assign dy  = x_r >>> step_r;
  assign arc = $signed({2'b00, arc_of(step_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        x_r    <= TrigGain;
        y_r    <= '0;
        z_r    <= $signed({4'b0, phase[29:0]});
        quad_r <= phase[31:30];
      end else if (run_r) begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - arc;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + arc;
        end
        if (step_r == StepW'(TrigSteps - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;

  always_comb begin
    case (quad_r)
      2'd0: begin cos_q = x_r;  sin_q = y_r;  end
      2'd1: begin cos_q = -y_r; sin_q = x_r;  end
      2'd2: begin cos_q = -x_r; sin_q = -y_r; end
      default: begin cos_q = y_r; sin_q = -x_r; end
    endcase
  end

endmodule

>>> src/dft_lowpass_filter_core.sv
// Truncated-DFT low-pass filter. A load request (command 0) folds one Q16.16 sample
// into the cosine and sine sums of modes 0..M-1; a load at index 0 clears the sums
// first. A read request (command 1) rebuilds the sample from the kept modes and
// returns one result strobe on out_valid; a load returns nothing. Each non-zero
// mode runs a serial 24-step CORDIC, with phase and multiply steps around it, once
// on load and twice on read. busy is high for the whole request; results cannot be
// stalled.
module dft_lowpass_filter_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dftlp_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output dftlp_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import dftlp_pkg::*;

  state_t state_r, state_nxt;

  logic [9:0]  n_count_r;
  logic [6:0]  m_count_r;
  logic [31:0] phase_step_r, recip_r;

  in_item_t           req_r;
  logic [ModeW:0]     k_r;
  logic [ModeW:0]     m_eff;
  logic               mirror_r;
  logic [9:0]         kmod_r;
  logic [18:0]        prod_r;
  logic [9:0]         rem_r;
  logic [31:0]        phase_r;
  logic signed [33:0] cos_r, sin_r;
  logic               part_r;
  logic signed [63:0] acc_r, total_r, cs_r, ss_r;
  logic signed [63:0] op_r;
  logic signed [33:0] trig_op;
  logic signed [63:0] hi_prod_r;
  logic [63:0]        mul_lo_r;
  logic               cordic_start, cordic_done;
  logic signed [33:0] c_q, s_q;
  logic               bad;
  logic               clr_r;
  logic [ModeW-1:0]   ram_waddr, ram_raddr;
  logic               ram_we;
  logic [63:0]        cs_wdata, ss_wdata, cs_rdata, ss_rdata;
  logic               out_valid_r;
  out_item_t          out_r;

  assign m_eff = (m_count_r == 7'd0) ? (ModeW+1)'(1) :
                 (m_count_r > 7'(MaxModes)) ? (ModeW+1)'(MaxModes) : (ModeW+1)'(m_count_r);
  assign bad   = {1'b0, req_r.sample_index} >= n_count_r;
  assign cfg_ready = (state_r == S_IDLE);

  dftlp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cordic_start), .phase(phase_r),
    .done(cordic_done), .cos_q(c_q), .sin_q(s_q)
  );

  dftlp_ram #(.Width(64), .Depth(MaxModes)) u_cos_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(cs_wdata),
    .rd_addr(ram_raddr), .rd_data(cs_rdata)
  );
  dftlp_ram #(.Width(64), .Depth(MaxModes)) u_sin_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ss_wdata),
    .rd_addr(ram_raddr), .rd_data(ss_rdata)
  );

  // product of the operand (sample on load, sum on read) and trig value, floor >> 30, split in a high and a low pass
  logic signed [63:0] mul_a;
  logic signed [33:0] mul_hi_a;
  logic signed [63:0] hi_part;
  logic signed [31:0] lo_a;
  logic signed [66:0] lo_full;
  logic signed [63:0] term;
  assign mul_a    = op_r;
  assign mul_hi_a = 34'(mul_a >>> 30);
  assign lo_a     = $signed({2'b00, mul_a[29:0]});
  assign lo_full  = 67'(lo_a) * 67'(trig_op);

  always_comb begin
    hi_part = 64'(mul_hi_a) * 64'(trig_op);
    term    = hi_prod_r + 64'(lo_full >>> 30);
  end

  // trig operand: cos for part 0, sin for part 1
  assign trig_op = part_r ? sin_r : cos_r;

  // scale multiply
  logic signed [63:0] sc_hi;
  logic [63:0]        sc_lo;
  logic signed [63:0] res;
  assign sc_hi = 64'($signed(total_r[63:32])) * $signed({32'b0, recip_r});
  assign sc_lo = {32'b0, total_r[31:0]} * {32'b0, recip_r};
  assign res   = hi_prod_r + $signed({32'b0, mul_lo_r[63:32]});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:       if (start) state_nxt = S_KSTART;
      S_CLEAR:      if (k_r == (ModeW+1)'(MaxModes - 1)) state_nxt = S_MODE0;
      S_MODE0:      state_nxt = S_RD_WAIT;
      S_KSTART:     state_nxt = S_PHMUL;
      S_PHMUL:      state_nxt = S_PHMOD;
      S_PHMOD:      if (prod_r < 19'(n_count_r)) state_nxt = S_REMMUL;
      S_REMMUL:     state_nxt = S_TRIG_START;
      S_TRIG_START: state_nxt = S_TRIG_WAIT;
      S_TRIG_WAIT:  if (cordic_done) state_nxt = S_RD_ISSUE;
      S_RD_ISSUE:   state_nxt = S_RD_WAIT;
      S_RD_WAIT:    state_nxt = S_MUL_HI;
      S_MUL_HI:     state_nxt = S_MUL_LO;
      S_MUL_LO:     state_nxt = S_MUL_ACC;
      S_MUL_ACC:    state_nxt = part_r ? S_WRITE : S_MUL_HI;
      S_WRITE:      state_nxt = S_NEXTK;
      S_NEXTK:      state_nxt = S_KSTART;
      S_SC_HI:      state_nxt = S_SC_LO;
      S_SC_LO:      state_nxt = S_DONE;
      S_DONE:       state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cordic_start = (state_r == S_TRIG_START);
    busy         = (state_r != S_IDLE);
    ram_raddr    = k_r[ModeW-1:0];
    ram_waddr    = k_r[ModeW-1:0];
    ram_we       = (state_r == S_CLEAR) || (state_r == S_WRITE && req_r.command == CMD_LOAD);
    cs_wdata     = clr_r ? 64'd0 : cs_r;
    ss_wdata     = clr_r ? 64'd0 : ss_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      k_r          <= '0;
      clr_r        <= 1'b1;
      n_count_r    <= 10'd365;
      m_count_r    <= 7'd1;
      phase_step_r <= 32'd11766976;
      recip_r      <= 32'd11766976;
      out_valid_r  <= 1'b0;
      req_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SAMPLE_COUNT: n_count_r    <= cfg_data[9:0];
          CFG_MODE_COUNT:   m_count_r    <= cfg_data[6:0];
          CFG_PHASE_STEP:   phase_step_r <= cfg_data;
          CFG_COUNT_RECIP:  recip_r      <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r    <= in_item;
            k_r      <= '0;
            mirror_r <= 1'b0;
            total_r  <= '0;
          end
        end
        S_CLEAR: begin
          k_r <= k_r + 1'b1;
          if (k_r == (ModeW+1)'(MaxModes - 1)) begin
            k_r   <= '0;
            clr_r <= 1'b0;
            if (req_r.command == CMD_LOAD && !bad && req_r.sample_index == 9'd0 && busy)
              ;
          end
        end
        S_MODE0: ;
        S_KSTART: begin
          if (bad) begin
            state_r <= (req_r.command == CMD_LOAD) ? S_IDLE : S_DONE;
            out_r   <= '{filtered_value: '0, index_error: 1'b1};
          end else if (k_r == '0 && req_r.command == CMD_LOAD &&
                       req_r.sample_index == 9'd0 && !clr_r && !part_r) begin
            clr_r   <= 1'b1;
            part_r  <= 1'b1;
            state_r <= S_CLEAR;
          end else if (k_r == '0) begin
            part_r  <= 1'b0;
            clr_r   <= 1'b0;
            state_r <= S_RD_ISSUE;
          end else if (k_r >= m_eff) begin
            state_r <= (req_r.command == CMD_LOAD) ? S_IDLE : S_SC_HI;
          end else begin
            kmod_r <= 10'(k_r);
            state_r <= S_PHMUL;
          end
        end
        S_PHMUL: begin
          if (kmod_r >= n_count_r) begin
            kmod_r  <= kmod_r - n_count_r;
            state_r <= S_PHMUL;
          end else begin
            prod_r <= (mirror_r ? 19'((kmod_r == 10'd0) ? 10'd0 : n_count_r - kmod_r)
                                : 19'(kmod_r)) * 19'(req_r.sample_index);
          end
        end
        S_PHMOD: if (prod_r >= 19'(n_count_r)) prod_r <= prod_r - 19'(n_count_r);
        S_REMMUL: phase_r <= 32'(prod_r) * phase_step_r;
        S_TRIG_START: ;
        S_TRIG_WAIT: if (cordic_done) begin cos_r <= c_q; sin_r <= s_q; end
        S_RD_ISSUE: ;
        S_RD_WAIT: begin
          cs_r   <= cs_rdata;
          ss_r   <= ss_rdata;
          part_r <= 1'b0;
          if (k_r == '0) begin
            if (req_r.command == CMD_LOAD)
              cs_r <= (clr_r ? 64'd0 : cs_rdata) + 64'(req_r.sample_value);
            else
              total_r <= cs_rdata;
            state_r <= (req_r.command == CMD_LOAD) ? S_WRITE : S_NEXTK;
          end else begin
            op_r <= (req_r.command == CMD_LOAD) ? 64'(req_r.sample_value) : cs_rdata;
          end
        end
        S_MUL_HI: hi_prod_r <= hi_part;
        S_MUL_LO: acc_r <= term;
        S_MUL_ACC: begin
          if (req_r.command == CMD_LOAD) begin
            if (!part_r) cs_r <= cs_r + acc_r;
            else         ss_r <= ss_r - acc_r;
          end else begin
            if (!part_r)       total_r <= total_r + acc_r;
            else if (mirror_r) total_r <= total_r + acc_r;
            else               total_r <= total_r - acc_r;
          end
          part_r <= ~part_r;
          if (!part_r) op_r <= (req_r.command == CMD_LOAD) ? 64'(req_r.sample_value) : ss_r;
        end
        S_WRITE: clr_r <= 1'b0;
        S_NEXTK: begin
          if (req_r.command == CMD_READ && k_r != '0 && !mirror_r) begin
            mirror_r <= 1'b1;
            kmod_r   <= 10'(k_r);
            state_r  <= S_PHMUL;
          end else begin
            mirror_r <= 1'b0;
            k_r      <= k_r + 1'b1;
          end
        end
        S_SC_HI: begin
          hi_prod_r <= sc_hi;
          mul_lo_r  <= sc_lo;
        end
        S_SC_LO: begin
          out_r.index_error <= 1'b0;
          if (res > 64'sd2147483647)       out_r.filtered_value <= 32'sh7fffffff;
          else if (res < -64'sd2147483648) out_r.filtered_value <= 32'sh80000000;
          else                             out_r.filtered_value <= res[31:0];
        end
        S_DONE: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
